// ===== hw/rtl/tlvp_pkg.sv =====
// Shared tags, parser phases, result kinds and result word type for the TLV record parser.
package tlvp_pkg;

  // Record tags
  localparam logic [31:0] TAG_START     = 32'h0000_0000;
  localparam logic [31:0] TAG_FILENAME  = 32'h0000_0001;
  localparam logic [31:0] TAG_PARTITION = 32'h0000_0002;
  localparam logic [31:0] TAG_ADD       = 32'h0000_0003;
  localparam logic [31:0] TAG_RM        = 32'h0000_0004;
  localparam logic [31:0] TAG_DATA      = 32'h0000_0005;
  localparam logic [31:0] TAG_MODE      = 32'h0000_0006;
  localparam logic [31:0] TAG_OWNER     = 32'h0000_0007;
  localparam logic [31:0] TAG_END       = 32'hFFFF_FFFF;

  // Parser phases
  localparam int unsigned PHASE_W = 3;
  localparam logic [PHASE_W-1:0] PH_OUTER_TAG  = 3'd0;
  localparam logic [PHASE_W-1:0] PH_OUTER_LEN  = 3'd1;
  localparam logic [PHASE_W-1:0] PH_SKIP       = 3'd2;
  localparam logic [PHASE_W-1:0] PH_START_WORD = 3'd3;
  localparam logic [PHASE_W-1:0] PH_INNER_TAG  = 3'd4;
  localparam logic [PHASE_W-1:0] PH_INNER_LEN  = 3'd5;
  localparam logic [PHASE_W-1:0] PH_STREAM     = 3'd6;
  localparam logic [PHASE_W-1:0] PH_WORD       = 3'd7;

  // Result kinds
  localparam logic [2:0] KIND_FILENAME = 3'd0;
  localparam logic [2:0] KIND_OWNER    = 3'd1;
  localparam logic [2:0] KIND_DATA     = 3'd2;
  localparam logic [2:0] KIND_DONE     = 3'd3;
  localparam logic [2:0] KIND_BUF_END  = 3'd4;
  localparam logic [2:0] KIND_TRUNC    = 3'd5;

  // Held flag bits
  localparam int unsigned FLAG_PART = 0;
  localparam int unsigned FLAG_MODE = 1;
  localparam int unsigned FLAG_RM   = 2;

  // Result queue
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QAW    = $clog2(QDEPTH);
  localparam int unsigned QCW    = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [2:0]  result_kind;
    logic [7:0]  payload_byte;
    logic [31:0] partition_id;
    logic        partition_given;
    logic [31:0] file_mode;
    logic        mode_given;
    logic        remove_action;
    logic [31:0] data_length;
    logic        buffer_done;
  } tlvp_res_t;

  typedef struct packed {
    logic      valid;
    tlvp_res_t res;
  } tlvp_xfer_t;

endpackage

// ===== hw/rtl/tlvp_if.sv =====
// Byte input and result output channel interfaces of the TLV record parser.
interface tlvp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       buffer_last;

  modport source (output valid, output data_byte, output buffer_last, input ready);
  modport sink   (input valid, input data_byte, input buffer_last, output ready);
endinterface

interface tlvp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  result_kind;
  logic [7:0]  payload_byte;
  logic [31:0] partition_id;
  logic        partition_given;
  logic [31:0] file_mode;
  logic        mode_given;
  logic        remove_action;
  logic [31:0] data_length;
  logic        buffer_done;

  modport source (
    output valid, output result_kind, output payload_byte, output partition_id,
    output partition_given, output file_mode, output mode_given,
    output remove_action, output data_length, output buffer_done,
    input ready
  );
  modport sink (
    input valid, input result_kind, input payload_byte, input partition_id,
    input partition_given, input file_mode, input mode_given,
    input remove_action, input data_length, input buffer_done,
    output ready
  );
endinterface

// ===== hw/rtl/tlvp_front.sv =====
// Front end: accepts buffer bytes, walks the record structure and builds result words.
module tlvp_front (
  input  logic                clk,
  input  logic                rst_n,
  tlvp_in_if.sink             in_bus,
  input  logic                q_full,
  output tlvp_pkg::tlvp_xfer_t push
);
  import tlvp_pkg::*;

  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic [31:0]        word_shift_r, word_shift_nxt;
  logic [31:0]        tag_r, tag_nxt;
  logic [31:0]        remaining_r, remaining_nxt;
  logic [1:0]         biw_r, biw_nxt;
  logic [31:0]        held_part_r, held_part_nxt;
  logic [31:0]        held_mode_r, held_mode_nxt;
  logic [31:0]        held_dlen_r, held_dlen_nxt;
  logic [2:0]         flags_r, flags_nxt;

  logic        accept;
  logic        word_done;
  logic        have;
  logic        clean;
  logic [31:0] w;
  tlvp_res_t   res;

  assign in_bus.ready = !q_full;
  assign accept = in_bus.valid && in_bus.ready;
  assign w = {word_shift_r[23:0], in_bus.data_byte};

  always_comb begin
    phase_nxt      = phase_r;
    word_shift_nxt = word_shift_r;
    tag_nxt        = tag_r;
    remaining_nxt  = remaining_r;
    biw_nxt        = biw_r;
    held_part_nxt  = held_part_r;
    held_mode_nxt  = held_mode_r;
    held_dlen_nxt  = held_dlen_r;
    flags_nxt      = flags_r;
    word_done      = 1'b0;
    have           = 1'b0;
    clean          = 1'b0;
    res            = '0;

    if (phase_r == PH_SKIP || phase_r == PH_STREAM) begin
      if (phase_r == PH_STREAM) begin
        have = 1'b1;
        res.payload_byte = in_bus.data_byte;
        if (tag_r == TAG_FILENAME) begin
          res.result_kind = KIND_FILENAME;
        end else if (tag_r == TAG_OWNER) begin
          res.result_kind = KIND_OWNER;
        end else begin
          res.result_kind = KIND_DATA;
        end
      end
      remaining_nxt = remaining_r - 32'd1;
      if (remaining_r == 32'd1) begin
        phase_nxt = (phase_r == PH_SKIP) ? PH_OUTER_TAG : PH_INNER_TAG;
      end
    end else begin
      word_shift_nxt = w;
      if (biw_r == 2'd3) begin
        biw_nxt   = 2'd0;
        word_done = 1'b1;
      end else begin
        biw_nxt = biw_r + 2'd1;
      end
    end

    if (word_done) begin
      case (phase_r)
        PH_OUTER_TAG: begin
          tag_nxt   = w;
          phase_nxt = PH_OUTER_LEN;
        end
        PH_OUTER_LEN: begin
          if (tag_r == TAG_START) begin
            phase_nxt = PH_START_WORD;
          end else if (w == 32'd0) begin
            phase_nxt = PH_OUTER_TAG;
          end else begin
            remaining_nxt = w;
            phase_nxt     = PH_SKIP;
          end
        end
        PH_START_WORD: begin
          phase_nxt = PH_INNER_TAG;
        end
        PH_INNER_TAG: begin
          tag_nxt   = w;
          phase_nxt = PH_INNER_LEN;
        end
        PH_INNER_LEN: begin
          if (tag_r inside {TAG_FILENAME, TAG_OWNER, TAG_DATA}) begin
            if (tag_r == TAG_DATA) begin
              held_dlen_nxt = w;
            end
            remaining_nxt = w;
            phase_nxt     = (w == 32'd0) ? PH_INNER_TAG : PH_STREAM;
          end else if (tag_r inside {TAG_PARTITION, TAG_ADD, TAG_RM, TAG_MODE, TAG_END}) begin
            phase_nxt = PH_WORD;
          end else begin
            phase_nxt = PH_INNER_TAG;
          end
        end
        PH_WORD: begin
          phase_nxt = PH_INNER_TAG;
          if (tag_r == TAG_PARTITION) begin
            held_part_nxt        = w;
            flags_nxt[FLAG_PART] = 1'b1;
          end else if (tag_r == TAG_ADD) begin
            flags_nxt[FLAG_RM] = 1'b0;
          end else if (tag_r == TAG_RM) begin
            flags_nxt[FLAG_RM] = 1'b1;
          end else if (tag_r == TAG_MODE) begin
            held_mode_nxt        = w;
            flags_nxt[FLAG_MODE] = 1'b1;
          end else begin
            have                = 1'b1;
            res.result_kind     = KIND_DONE;
            res.partition_id    = flags_r[FLAG_PART] ? held_part_r : 32'd0;
            res.partition_given = flags_r[FLAG_PART];
            res.file_mode       = flags_r[FLAG_MODE] ? held_mode_r : 32'd0;
            res.mode_given      = flags_r[FLAG_MODE];
            res.remove_action   = flags_r[FLAG_RM];
            res.data_length     = held_dlen_r;
            held_part_nxt       = 32'd0;
            held_mode_nxt       = 32'd0;
            held_dlen_nxt       = 32'd0;
            flags_nxt           = 3'd0;
            phase_nxt           = PH_OUTER_TAG;
          end
        end
        default: begin
        end
      endcase
    end

    // Final byte: report the buffer outcome and return to the idle state
    if (in_bus.buffer_last) begin
      clean = (phase_nxt == PH_OUTER_TAG) && (biw_nxt == 2'd0);
      if (!(clean && have && res.result_kind == KIND_DONE)) begin
        res             = '0;
        res.result_kind = clean ? KIND_BUF_END : KIND_TRUNC;
      end
      res.buffer_done = 1'b1;
      have            = 1'b1;
      phase_nxt       = PH_OUTER_TAG;
      word_shift_nxt  = 32'd0;
      tag_nxt         = 32'd0;
      remaining_nxt   = 32'd0;
      biw_nxt         = 2'd0;
      held_part_nxt   = 32'd0;
      held_mode_nxt   = 32'd0;
      held_dlen_nxt   = 32'd0;
      flags_nxt       = 3'd0;
    end
  end

  assign push.valid = accept && have;
  assign push.res   = res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_OUTER_TAG;
      word_shift_r <= 32'd0;
      tag_r        <= 32'd0;
      remaining_r  <= 32'd0;
      biw_r        <= 2'd0;
      held_part_r  <= 32'd0;
      held_mode_r  <= 32'd0;
      held_dlen_r  <= 32'd0;
      flags_r      <= 3'd0;
    end else if (accept) begin
      phase_r      <= phase_nxt;
      word_shift_r <= word_shift_nxt;
      tag_r        <= tag_nxt;
      remaining_r  <= remaining_nxt;
      biw_r        <= biw_nxt;
      held_part_r  <= held_part_nxt;
      held_mode_r  <= held_mode_nxt;
      held_dlen_r  <= held_dlen_nxt;
      flags_r      <= flags_nxt;
    end
  end

endmodule

// ===== hw/rtl/tlvp_queue.sv =====
// Short result queue between the parser front end and the output stage.
module tlvp_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  tlvp_pkg::tlvp_xfer_t push,
  output logic                 q_full,
  output tlvp_pkg::tlvp_xfer_t head,
  input  logic                 pop
);
  import tlvp_pkg::*;

  tlvp_res_t        slot_r [QDEPTH];
  logic [QAW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0]   count_r, count_nxt;
  logic             do_pop;

  assign q_full     = (count_r == QCW'(QDEPTH));
  assign head.valid = (count_r != '0);
  assign head.res   = slot_r[rd_ptr_r];
  assign do_pop     = pop && head.valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push.valid) begin
      wr_ptr_nxt = (wr_ptr_r == QAW'(QDEPTH - 1)) ? '0 : wr_ptr_r + QAW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QAW'(QDEPTH - 1)) ? '0 : rd_ptr_r + QAW'(1);
    end
    if (push.valid && !do_pop) begin
      count_nxt = count_r + QCW'(1);
    end else if (!push.valid && do_pop) begin
      count_nxt = count_r - QCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      slot_r[wr_ptr_r] <= push.res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== hw/rtl/tlvp_back.sv =====
// Output stage: pulls result words from the queue into the registered result channel.
module tlvp_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  tlvp_pkg::tlvp_xfer_t head,
  output logic                 pop,
  tlvp_out_if.source           out_bus
);
  import tlvp_pkg::*;

  logic      out_valid_r, out_valid_nxt;
  tlvp_res_t out_res_r;

  // Load a new word when the register is empty or its word is taken this cycle
  assign pop = head.valid && (!out_valid_r || out_bus.ready);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_bus.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_res_r <= head.res;
    end
  end

  assign out_bus.valid           = out_valid_r;
  assign out_bus.result_kind     = out_res_r.result_kind;
  assign out_bus.payload_byte    = out_res_r.payload_byte;
  assign out_bus.partition_id    = out_res_r.partition_id;
  assign out_bus.partition_given = out_res_r.partition_given;
  assign out_bus.file_mode       = out_res_r.file_mode;
  assign out_bus.mode_given      = out_res_r.mode_given;
  assign out_bus.remove_action   = out_res_r.remove_action;
  assign out_bus.data_length     = out_res_r.data_length;
  assign out_bus.buffer_done     = out_res_r.buffer_done;

endmodule

// ===== hw/rtl/tlv_config_record_parser.sv =====
// Top level of the TLV configuration record parser: front end, result queue, output stage.
//
// The parser takes one buffer byte per cycle while the result queue has room and gives
// at most one result word per byte. Bytes that only advance the header, length or word
// counters give no word; filename, owner and data payload bytes give one word each, the
// END word of a record gives "record done" with the collected partition, mode, action and
// data length, and the final byte of a buffer (buffer_last) gives "buffer end" or
// "truncated" (or "record done" when it closes a record) with buffer_done set. A word
// passes through the result queue and then the registered output stage. Input ready
// depends only on the two-entry result queue: as long as the output side takes words,
// in_bus.ready stays high and the rate is one byte per cycle; when the output stalls,
// the queue absorbs two words and then ready drops until a word leaves. After
// buffer_last the parser is back in its reset state for the next buffer.
module tlv_config_record_parser (
  input  logic        clk,
  input  logic        rst_n,
  tlvp_in_if.sink     in_bus,
  tlvp_out_if.source  out_bus
);
  import tlvp_pkg::*;

  tlvp_xfer_t push;
  tlvp_xfer_t head;
  logic       q_full;
  logic       pop;

  // Parse: classify each byte and build the result word it causes
  tlvp_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_bus),
    .q_full (q_full),
    .push   (push)
  );

  // Buffer result words so the parser keeps going while the output stalls
  tlvp_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .q_full (q_full),
    .head   (head),
    .pop    (pop)
  );

  // Present words on the registered output channel
  tlvp_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .head    (head),
    .pop     (pop),
    .out_bus (out_bus)
  );

endmodule

// ===== hw/rtl/tlvp_checker.sv =====
// Port-level checks of the TLV record parser and their bind to the top level.
module tlvp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_result_kind,
  input logic [7:0]  out_payload_byte,
  input logic [31:0] out_partition_id,
  input logic        out_partition_given,
  input logic [31:0] out_file_mode,
  input logic        out_mode_given,
  input logic        out_remove_action,
  input logic [31:0] out_data_length,
  input logic        out_buffer_done
);
  import tlvp_pkg::*;

  // A stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_kind) &&
      $stable(out_payload_byte) && $stable(out_data_length) && $stable(out_buffer_done))
    else $error("result word changed while stalled");

  // Record fields appear only on a record done word
  a_rec_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind != KIND_DONE |->
      out_partition_id == 32'd0 && !out_partition_given && out_file_mode == 32'd0 &&
      !out_mode_given && !out_remove_action && out_data_length == 32'd0)
    else $error("record fields set on a non-record word");

  // Only payload kinds carry a byte
  a_no_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_result_kind == KIND_DONE || out_result_kind == KIND_BUF_END ||
      out_result_kind == KIND_TRUNC) |-> out_payload_byte == 8'd0)
    else $error("payload byte on a non-payload word");

  // Buffer end and truncation are final-byte results
  a_end_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_result_kind == KIND_BUF_END || out_result_kind == KIND_TRUNC) |->
      out_buffer_done)
    else $error("buffer end word without buffer_done");

  // Reset empties the output
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind tlv_config_record_parser tlvp_checker u_tlvp_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_bus.valid),
  .out_ready           (out_bus.ready),
  .out_result_kind     (out_bus.result_kind),
  .out_payload_byte    (out_bus.payload_byte),
  .out_partition_id    (out_bus.partition_id),
  .out_partition_given (out_bus.partition_given),
  .out_file_mode       (out_bus.file_mode),
  .out_mode_given      (out_bus.mode_given),
  .out_remove_action   (out_bus.remove_action),
  .out_data_length     (out_bus.data_length),
  .out_buffer_done     (out_bus.buffer_done)
);

// ===== dv/testbench.sv =====
// Self-checking testbench of the TLV configuration record parser: byte stream in, result words out.
`timescale 1ns / 1ps

import tlvp_pkg::*;

// Tracks the parser state byte by byte and holds the result words still owed by the block.
class tlv_record_tracker;
  logic [PHASE_W-1:0] phase;
  logic [31:0]        shift_word;
  logic [31:0]        tag;
  logic [31:0]        remaining;
  logic [1:0]         byte_idx;
  logic [31:0]        part_word;
  logic [31:0]        mode_word;
  logic [31:0]        data_len;
  logic [2:0]         flags;
  tlvp_res_t          owed[$];
  int                 mismatches;

  function new();
    mismatches = 0;
    restart();
  endfunction

  function void restart();
    phase      = PH_OUTER_TAG;
    shift_word = '0;
    tag        = '0;
    remaining  = '0;
    byte_idx   = '0;
    part_word  = '0;
    mode_word  = '0;
    data_len   = '0;
    flags      = '0;
  endfunction

  // Advance the parser by one accepted byte and queue the result word it causes, if any.
  function void parse_byte(logic [7:0] b, logic last_byte);
    tlvp_res_t r;
    bit        have;
    bit        word_done;
    bit        clean;
    logic [31:0] w;
    r = '0;
    have = 0;
    word_done = 0;
    w = '0;
    if (phase == PH_SKIP || phase == PH_STREAM) begin
      if (phase == PH_STREAM) begin
        have = 1;
        r.result_kind = (tag == TAG_FILENAME) ? KIND_FILENAME :
                        (tag == TAG_OWNER) ? KIND_OWNER : KIND_DATA;
        r.payload_byte = b;
      end
      remaining = remaining - 32'd1;
      if (remaining == 32'd0) begin
        phase = (phase == PH_SKIP) ? PH_OUTER_TAG : PH_INNER_TAG;
      end
    end else begin
      w = {shift_word[23:0], b};
      shift_word = w;
      if (byte_idx == 2'd3) begin
        byte_idx = 2'd0;
        word_done = 1;
      end else begin
        byte_idx = byte_idx + 2'd1;
      end
    end

    if (word_done) begin
      case (phase)
        PH_OUTER_TAG: begin
          tag = w;
          phase = PH_OUTER_LEN;
        end
        PH_OUTER_LEN: begin
          if (tag == TAG_START) begin
            phase = PH_START_WORD;
          end else if (w == 32'd0) begin
            phase = PH_OUTER_TAG;
          end else begin
            remaining = w;
            phase = PH_SKIP;
          end
        end
        PH_START_WORD: begin
          phase = PH_INNER_TAG;
        end
        PH_INNER_TAG: begin
          tag = w;
          phase = PH_INNER_LEN;
        end
        PH_INNER_LEN: begin
          if (tag == TAG_FILENAME || tag == TAG_OWNER || tag == TAG_DATA) begin
            if (tag == TAG_DATA) data_len = w;
            remaining = w;
            phase = (w == 32'd0) ? PH_INNER_TAG : PH_STREAM;
          end else if (tag == TAG_PARTITION || tag == TAG_ADD || tag == TAG_RM ||
                       tag == TAG_MODE || tag == TAG_END) begin
            phase = PH_WORD;
          end else begin
            phase = PH_INNER_TAG;
          end
        end
        default: begin
          phase = PH_INNER_TAG;
          if (tag == TAG_PARTITION) begin
            part_word = w;
            flags[FLAG_PART] = 1'b1;
          end else if (tag == TAG_ADD) begin
            flags[FLAG_RM] = 1'b0;
          end else if (tag == TAG_RM) begin
            flags[FLAG_RM] = 1'b1;
          end else if (tag == TAG_MODE) begin
            mode_word = w;
            flags[FLAG_MODE] = 1'b1;
          end else begin
            have = 1;
            r.result_kind     = KIND_DONE;
            r.partition_id    = flags[FLAG_PART] ? part_word : 32'd0;
            r.partition_given = flags[FLAG_PART];
            r.file_mode       = flags[FLAG_MODE] ? mode_word : 32'd0;
            r.mode_given      = flags[FLAG_MODE];
            r.remove_action   = flags[FLAG_RM];
            r.data_length     = data_len;
            part_word = '0;
            mode_word = '0;
            data_len  = '0;
            flags     = '0;
            phase = PH_OUTER_TAG;
          end
        end
      endcase
    end

    if (last_byte) begin
      clean = (phase == PH_OUTER_TAG) && (byte_idx == 2'd0);
      if (!(clean && have && r.result_kind == KIND_DONE)) begin
        r = '0;
        r.result_kind = clean ? KIND_BUF_END : KIND_TRUNC;
      end
      r.buffer_done = 1'b1;
      have = 1;
      restart();
    end

    if (have) owed.push_back(r);
  endfunction

  function string show(tlvp_res_t r);
    return $sformatf("kind=%0d byte=%h part=%h/%b mode=%h/%b rm=%b len=%h done=%b",
                     r.result_kind, r.payload_byte, r.partition_id, r.partition_given,
                     r.file_mode, r.mode_given, r.remove_action, r.data_length,
                     r.buffer_done);
  endfunction

  function void flag_error(string what);
    mismatches++;
    if (mismatches <= 10) $display("%t mismatch: %s", $realtime, what);
  endfunction

  // Compare one result word with the oldest one owed.
  function void check_result(tlvp_res_t got);
    tlvp_res_t want;
    if (owed.size() == 0) begin
      flag_error({"unexpected word ", show(got)});
    end else begin
      want = owed.pop_front();
      if (got.result_kind !== want.result_kind || got.payload_byte !== want.payload_byte ||
          got.partition_id !== want.partition_id ||
          got.partition_given !== want.partition_given ||
          got.file_mode !== want.file_mode || got.mode_given !== want.mode_given ||
          got.remove_action !== want.remove_action ||
          got.data_length !== want.data_length || got.buffer_done !== want.buffer_done) begin
        flag_error({"expected ", show(want), " actual ", show(got)});
      end
    end
  endfunction
endclass

module testbench;
  localparam int unsigned CYCLE_LIMIT = 400_000;
  localparam int unsigned RANDOM_BYTES = 1000;
  localparam int unsigned CALM_BYTES = 150;

  logic clk;
  logic rst_n;
  int unsigned cycle_count = 0;
  bit calm_tail = 0;

  // Each entry is one input word: bit 8 is buffer_last, bits 7:0 the byte.
  logic [8:0] byte_plan[$];

  tlv_record_tracker tracker = new();

  tlvp_in_if  in_bus();
  tlvp_out_if out_bus();

  tlv_config_record_parser u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop: a hung handshake must not run forever.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Sample every accepted result word and check it against the oldest one owed.
  always @(posedge clk) begin
    tlvp_res_t got;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      got.result_kind     = out_bus.result_kind;
      got.payload_byte    = out_bus.payload_byte;
      got.partition_id    = out_bus.partition_id;
      got.partition_given = out_bus.partition_given;
      got.file_mode       = out_bus.file_mode;
      got.mode_given      = out_bus.mode_given;
      got.remove_action   = out_bus.remove_action;
      got.data_length     = out_bus.data_length;
      got.buffer_done     = out_bus.buffer_done;
      tracker.check_result(got);
    end
  end

  // Result side: stall in random bursts, hold ready high through the calm tail.
  initial begin
    out_bus.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!calm_tail && $urandom_range(0, 4) == 0) begin
        out_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      out_bus.ready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  end

  // Queue a 32-bit field big-endian.
  task automatic put_word(input logic [31:0] w);
    for (int i = 3; i >= 0; i--) byte_plan.push_back({1'b0, w[8*i +: 8]});
  endtask

  task automatic put_header(input logic [31:0] tag, input logic [31:0] len);
    put_word(tag);
    put_word(len);
  endtask

  task automatic put_payload(input int unsigned n);
    repeat (n) byte_plan.push_back({1'b0, 8'($urandom)});
  endtask

  // Flag the newest queued byte as the end of the buffer.
  task automatic mark_last();
    byte_plan[byte_plan.size() - 1][8] = 1'b1;
  endtask

  function automatic logic [31:0] pick_field();
    case ($urandom_range(0, 3))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // One inner record: streamed, fixed 32-bit field, unknown, or START nested inside.
  task automatic put_random_inner();
    logic [31:0] tag;
    int unsigned len;
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        case ($urandom_range(0, 2))
          0: tag = TAG_FILENAME;
          1: tag = TAG_OWNER;
          default: tag = TAG_DATA;
        endcase
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 24) : $urandom_range(0, 5);
        put_header(tag, len);
        put_payload(len);
      end
      3, 4, 5, 6, 7: begin
        case ($urandom_range(0, 3))
          0: tag = TAG_PARTITION;
          1: tag = TAG_ADD;
          2: tag = TAG_RM;
          default: tag = TAG_MODE;
        endcase
        // the length of a fixed field is ignored, so drive anything there
        put_header(tag, pick_field());
        put_word(pick_field());
      end
      8: begin
        tag = $urandom_range(0, 1) ? 32'(8 + $urandom_range(0, 300)) : 32'($urandom);
        if (tag <= TAG_OWNER || tag == TAG_END) tag = 32'h0000_0008;
        put_header(tag, pick_field());
      end
      default: begin
        put_header(TAG_START, pick_field());
      end
    endcase
  endtask

  // Mostly well-formed START records, some outer records to skip, some left unclosed.
  task automatic put_random_record();
    logic [31:0] tag;
    int unsigned len;
    if ($urandom_range(0, 6) == 0) begin
      tag = $urandom_range(0, 1) ? 32'($urandom_range(1, 9)) : 32'($urandom);
      if (tag == TAG_START) tag = TAG_FILENAME;
      len = $urandom_range(0, 6);
      put_header(tag, len);
      put_payload(len);
    end else begin
      put_header(TAG_START, pick_field());
      put_word(pick_field());
      repeat ($urandom_range(0, 6)) put_random_inner();
      if ($urandom_range(0, 9) != 0) begin
        put_header(TAG_END, pick_field());
        put_word(pick_field());
      end
    end
  endtask

  task automatic put_random_buffer();
    int unsigned first;
    int unsigned pick;
    int unsigned cut;
    first = byte_plan.size();
    repeat ($urandom_range(1, 3)) put_random_record();
    pick = $urandom_range(0, 19);
    if (pick < 14) begin
      mark_last();
    end else if (pick < 17) begin
      // cut the buffer at a random byte
      cut = $urandom_range(first, byte_plan.size() - 1);
      while (byte_plan.size() > cut + 1) void'(byte_plan.pop_back());
      mark_last();
    end else if (pick < 19) begin
      put_payload($urandom_range(1, 10));
      mark_last();
    end else begin
      // huge data length, cut short by the buffer end
      put_header(TAG_START, 32'd0);
      put_word(32'd0);
      put_header(TAG_DATA, 32'hFFFF_0000 | 32'($urandom_range(0, 65535)));
      put_payload($urandom_range(1, 8));
      mark_last();
    end
  endtask

  // Feed the planned bytes, with random gaps until the calm tail.
  task automatic drive_bytes();
    logic [8:0] entry;
    while (byte_plan.size() != 0) begin
      entry = byte_plan.pop_front();
      if (byte_plan.size() < CALM_BYTES) calm_tail = 1;
      if (!calm_tail && $urandom_range(0, 5) == 0) begin
        in_bus.valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      in_bus.valid       <= 1'b1;
      in_bus.data_byte   <= entry[7:0];
      in_bus.buffer_last <= entry[8];
      do @(posedge clk); while (!in_bus.ready);
      tracker.parse_byte(entry[7:0], entry[8]);
    end
    in_bus.valid <= 1'b0;
  endtask

  initial begin
    int unsigned directed_bytes;
    rst_n              <= 1'b0;
    in_bus.valid       <= 1'b0;
    in_bus.data_byte   <= 8'h00;
    in_bus.buffer_last <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Every inner tag in one record, closed by the final byte of the buffer.
    // The START length is ignored; fixed fields ignore their own lengths.
    put_header(TAG_START, 32'hFFFF_FFFF);
    put_word(32'h1234_5678);
    put_header(TAG_FILENAME, 32'd2);
    byte_plan.push_back({1'b0, 8'h00});
    byte_plan.push_back({1'b0, 8'hFF});
    put_header(TAG_OWNER, 32'd1);
    put_payload(1);
    put_header(TAG_DATA, 32'd0);
    put_header(TAG_DATA, 32'd3);
    put_payload(3);
    put_header(TAG_PARTITION, 32'd0);
    put_word(32'hFFFF_FFFF);
    put_header(TAG_MODE, 32'hFFFF_FFFF);
    put_word(32'h0000_01ED);
    put_header(TAG_RM, 32'd4);
    put_word(32'd0);
    put_header(TAG_ADD, 32'd4);
    put_word(32'd0);
    put_header(TAG_RM, 32'd4);
    put_word(32'hFFFF_FFFF);
    // repeated partition: the last one wins
    put_header(TAG_PARTITION, 32'd4);
    put_word(32'h0000_0003);
    // unknown tag and a nested START consume only their headers
    put_header(32'h0000_0042, 32'h0000_0010);
    put_header(TAG_START, 32'd5);
    put_header(TAG_END, 32'd0);
    put_word(32'd0);
    mark_last();

    // Closed mid-buffer, then skipped outer records: zero length ends at its header.
    put_header(TAG_START, 32'd0);
    put_word(32'd0);
    put_header(TAG_END, 32'd4);
    put_word(32'd0);
    put_header(32'h0000_0009, 32'd0);
    put_header(TAG_END, 32'd3);
    put_payload(3);
    mark_last();

    // Truncated in an owner payload: the final payload byte is dropped.
    put_header(TAG_START, 32'd0);
    put_word(32'd0);
    put_header(TAG_OWNER, 32'd4);
    put_payload(2);
    mark_last();

    // One-byte buffer, then a huge skip cut short.
    byte_plan.push_back({1'b1, 8'hA5});
    put_header(TAG_FILENAME, 32'hFFFF_FFFF);
    put_payload(5);
    mark_last();

    // Buffer ends between inner headers of an open record.
    put_header(TAG_START, 32'd0);
    put_word(32'hFFFF_FFFF);
    mark_last();

    directed_bytes = byte_plan.size();
    while (byte_plan.size() < directed_bytes + RANDOM_BYTES) put_random_buffer();

    drive_bytes();

    // Drain: wait for the owed words, then give the output stage time to misbehave.
    while (tracker.owed.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (tracker.mismatches == 0 && tracker.owed.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
